>>> sv/tat_pkg.sv
package tat_pkg;

   localparam int TPS_W     = 10;
   localparam int QUANTUM_W = 16;
   localparam int TASKS_W   = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int BILLED_W  = 6;

   localparam logic [TPS_W-1:0]     TPS_RESET     = 10'd60;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd6;
   localparam logic [TASKS_W-1:0]   TASKS_RESET   = 6'd8;
   localparam logic [BILLED_W-1:0]  NO_BILLED     = 6'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM_TICKS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_SLOT_COUNT  = 2'd2;

   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_SET_ALARM = 2'd1;
   localparam logic [1:0] OP_GET_TIME  = 2'd2;
   localparam logic [1:0] OP_SET_TIME  = 2'd3;

   localparam logic [2:0] KIND_FIRED     = 3'd0;
   localparam logic [2:0] KIND_TICK_DONE = 3'd1;
   localparam logic [2:0] KIND_SECONDS   = 3'd2;
   localparam logic [2:0] KIND_TIME      = 3'd3;
   localparam logic [2:0] KIND_ACK       = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_CHK,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_QUANT,
      ST_SA_OLD,
      ST_DIV_WAIT
   } tat_state_type;

endpackage

>>> sv/tat_div.sv
module tat_div
   import tat_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] dividend,
   input  logic [TPS_W-1:0]     divisor,
   output logic                 busy,
   output logic [TIME_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(TIME_BITS + 1);

   logic [TPS_W-1:0]     rem_ff, rem_in;
   logic [TIME_BITS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TPS_W:0]       trial;
   logic                 fits;

   // restoring division, one quotient bit a cycle; a zero divisor gives all ones
   always_comb begin
      trial  = {rem_ff, quo_ff[TIME_BITS-1]};
      fits   = trial >= {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_W'(TIME_BITS);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? TPS_W'(trial - {1'b0, divisor}) : TPS_W'(trial);
         quo_in = {quo_ff[TIME_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

>>> sv/tick_alarm_timer_table.sv
// Tick clock with a table of per-slot alarms. An item is taken when start is
// high and busy low; busy stays high until the cycle in which the item's last
// result is presented, and results cannot be held off. Alarm entries are read
// one at a time, each through a read state and a compare state, from a table
// with registered read, and tick-to-second conversion runs on a serial divider
// of one bit a cycle. A tick that finds nothing due goes from its check state
// straight to the quantum state; a tick that scans reads min(NUM_SLOTS,32)
// entries first. Set alarm rescans the same entries, the division overlapping
// the rescan, or gives its result from its first state for a slot beyond the
// table; get time and set time wait on the divider.
module tick_alarm_timer_table
   import tat_pkg::*;
#(
   parameter int NUM_SLOTS = 32,
   parameter int TIME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [4:0]            req_slot,
   input  logic [31:0]           req_delta,
   input  logic [31:0]           req_wall_secs,
   input  logic [15:0]           req_missed_ticks,
   input  logic [4:0]            req_billed_slot,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_kind,
   output logic [4:0]            rsp_fired_slot,
   output logic                  rsp_is_task,
   output logic [31:0]           rsp_value,
   output logic                  rsp_reschedule,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SCAN_N = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
   localparam int SCAN_W = $clog2(SCAN_N + 1);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SCAN_N - 1);

   // configuration
   logic [TPS_W-1:0]     tps_ff;
   logic [QUANTUM_W-1:0] quantum_ticks_ff;
   logic [TASKS_W-1:0]   tasks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff           <= TPS_RESET;
         quantum_ticks_ff <= QUANTUM_RESET;
         tasks_ff         <= TASKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TICKS_PER_SECOND: tps_ff           <= csr_wdata[TPS_W-1:0];
            CSR_QUANTUM_TICKS:    quantum_ticks_ff <= csr_wdata[QUANTUM_W-1:0];
            CSR_TASK_SLOT_COUNT:  tasks_ff         <= csr_wdata[TASKS_W-1:0];
            default: ;
         endcase
      end
   end

   // alarm table
   logic [TIME_BITS-1:0] alarm_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [TIME_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_waddr, mem_raddr;
   logic [TIME_BITS-1:0] mem_wdata;
   logic [TIME_BITS-1:0] alarm_rd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         alarm_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff  <= alarm_mem[mem_raddr];
      rd_valid_ff <= valid_ff[mem_raddr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   assign alarm_rd = rd_valid_ff ? rd_data_ff : '0;

   // divider
   logic                 div_start, div_busy;
   logic [TIME_BITS-1:0] div_dividend, div_quotient;

   tat_div #(
      .TIME_BITS (TIME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (tps_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // sequencer state
   tat_state_type        state_ff, state_in;
   logic [TIME_BITS-1:0] clock_ff, clock_in;
   logic [TIME_BITS-1:0] boot_ff, boot_in;
   logic [TIME_BITS-1:0] earliest_ff, earliest_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic [BILLED_W-1:0]  prev_ff, prev_in;
   logic [SCAN_W-1:0]    scan_ff, scan_in;
   logic                 fire_ff, fire_in;
   logic                 need_div_ff, need_div_in;
   logic [1:0]           op_ff, op_in;
   logic [4:0]           slot_ff, slot_in;
   logic [31:0]          delta_ff, delta_in;
   logic [31:0]          newt_ff, newt_in;
   logic [4:0]           billed_ff, billed_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_kind_ff, rsp_kind_in;
   logic [4:0]           rsp_fired_slot_ff, rsp_fired_slot_in;
   logic                 rsp_is_task_ff, rsp_is_task_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;
   logic                 rsp_reschedule_ff, rsp_reschedule_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 slot_ok;
   logic [QUANTUM_W-1:0] quantum_dec;

   assign slot_ok     = int'(slot_ff) < NUM_SLOTS;
   assign quantum_dec = quantum_ff - QUANTUM_W'(1);

   always_comb begin
      state_in    = state_ff;
      clock_in    = clock_ff;
      boot_in     = boot_ff;
      earliest_in = earliest_ff;
      quantum_in  = quantum_ff;
      prev_in     = prev_ff;
      scan_in     = scan_ff;
      fire_in     = fire_ff;
      need_div_in = need_div_ff;
      op_in       = op_ff;
      slot_in     = slot_ff;
      delta_in    = delta_ff;
      newt_in     = newt_ff;
      billed_in   = billed_ff;

      mem_we       = 1'b0;
      mem_waddr    = SLOT_W'(slot_ff);
      mem_wdata    = '0;
      mem_raddr    = SLOT_W'(scan_ff);
      div_start    = 1'b0;
      div_dividend = clock_ff;

      rsp_valid_in      = 1'b0;
      rsp_kind_in       = KIND_FIRED;
      rsp_fired_slot_in = '0;
      rsp_is_task_in    = 1'b0;
      rsp_value_in      = '0;
      rsp_reschedule_in = 1'b0;
      rsp_last_in       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            mem_raddr = SLOT_W'(req_slot);
            if (start) begin
               op_in     = req_operation;
               slot_in   = req_slot;
               delta_in  = req_delta;
               newt_in   = req_wall_secs;
               billed_in = req_billed_slot;
               unique case (req_operation) inside
                  OP_TICK: begin
                     clock_in = clock_ff + TIME_BITS'(req_missed_ticks) + TIME_BITS'(1);
                     state_in = ST_TICK_CHK;
                  end
                  OP_SET_ALARM: begin
                     state_in = ST_SA_OLD;
                  end
                  OP_GET_TIME, OP_SET_TIME: begin
                     div_start = 1'b1;
                     state_in  = ST_DIV_WAIT;
                  end
               endcase
            end
         end
         ST_TICK_CHK: begin
            if (earliest_ff <= clock_ff) begin
               earliest_in = '1;
               scan_in     = '0;
               fire_in     = 1'b1;
               state_in    = ST_SCAN_RD;
            end else begin
               state_in = ST_QUANT;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (alarm_rd != '0) begin
               if (fire_ff && alarm_rd <= clock_ff) begin
                  mem_we            = 1'b1;
                  mem_waddr         = SLOT_W'(scan_ff);
                  rsp_valid_in      = 1'b1;
                  rsp_kind_in       = KIND_FIRED;
                  rsp_fired_slot_in = 5'(scan_ff);
                  rsp_is_task_in    = 7'(scan_ff) < 7'(tasks_ff);
               end else if (alarm_rd < earliest_ff) begin
                  earliest_in = alarm_rd;
               end
            end
            if (scan_ff == SCAN_LAST) begin
               state_in = fire_ff ? ST_QUANT : ST_DIV_WAIT;
            end else begin
               scan_in  = scan_ff + SCAN_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_QUANT: begin
            if (quantum_dec == '0) begin
               rsp_reschedule_in = BILLED_W'(billed_ff) == prev_ff;
               quantum_in        = quantum_ticks_ff;
               prev_in           = BILLED_W'(billed_ff);
            end else begin
               quantum_in = quantum_dec;
            end
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_TICK_DONE;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SA_OLD: begin
            if (slot_ok) begin
               mem_we       = 1'b1;
               mem_wdata    = (delta_ff == '0) ? '0 : clock_ff + TIME_BITS'(delta_ff);
               need_div_in  = alarm_rd != '0;
               div_start    = alarm_rd != '0;
               div_dividend = alarm_rd - clock_ff;
               earliest_in  = '1;
               scan_in      = '0;
               fire_in      = 1'b0;
               state_in     = ST_SCAN_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SECONDS;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV_WAIT: begin
            if (!div_busy) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               unique case (op_ff) inside
                  OP_SET_ALARM: begin
                     rsp_kind_in  = KIND_SECONDS;
                     rsp_value_in = need_div_ff ? 32'(div_quotient) : '0;
                  end
                  OP_GET_TIME: begin
                     rsp_kind_in  = KIND_TIME;
                     rsp_value_in = 32'(boot_ff + div_quotient);
                  end
                  OP_SET_TIME: begin
                     rsp_kind_in = KIND_ACK;
                     boot_in     = TIME_BITS'(newt_ff) - div_quotient;
                  end
                  OP_TICK: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ff     <= '0;
         boot_ff      <= '0;
         earliest_ff  <= '0;
         quantum_ff   <= QUANTUM_RESET;
         prev_ff      <= NO_BILLED;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         boot_ff      <= boot_in;
         earliest_ff  <= earliest_in;
         quantum_ff   <= quantum_in;
         prev_ff      <= prev_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff           <= scan_in;
      fire_ff           <= fire_in;
      need_div_ff       <= need_div_in;
      op_ff             <= op_in;
      slot_ff           <= slot_in;
      delta_ff          <= delta_in;
      newt_ff           <= newt_in;
      billed_ff         <= billed_in;
      rsp_kind_ff       <= rsp_kind_in;
      rsp_fired_slot_ff <= rsp_fired_slot_in;
      rsp_is_task_ff    <= rsp_is_task_in;
      rsp_value_ff      <= rsp_value_in;
      rsp_reschedule_ff <= rsp_reschedule_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_fired_slot = rsp_fired_slot_ff;
   assign rsp_is_task    = rsp_is_task_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_reschedule = rsp_reschedule_ff;
   assign rsp_last       = rsp_last_ff;

   a_idle_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_last)
      else $error("busy dropped without a final result");

   a_last_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result while still busy");

   a_fired_mid_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FIRED |-> busy && !rsp_last)
      else $error("alarm result outside a tick");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while running");

endmodule
